/* hdl/ilp_pkg.sv */
// ----------------------------------------------------------------------------
// ilp_pkg: shared types, constants and character helpers
// Defines the transaction structs of both channels and the character
// classification used by the integer literal parser.
// ----------------------------------------------------------------------------
package ilp_pkg;

  localparam int VALUE_BITS_DEF = 64;
  localparam int OUT_VALUE_W    = 64;
  localparam int CHAR_W         = 8;
  localparam int RADIX_W        = 5;
  localparam int SIZE_W         = 2;
  localparam int DIGIT_W        = 6;
  localparam int COUNT_W        = 3;
  localparam int TAIL_W         = 5 * CHAR_W;

  localparam logic [RADIX_W-1:0] RADIX_2  = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_3  = 5'd3;
  localparam logic [RADIX_W-1:0] RADIX_8  = 5'd8;
  localparam logic [RADIX_W-1:0] RADIX_10 = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_16 = 5'd16;
  localparam logic [RADIX_W-1:0] RADIX_NONE = 5'd0;

  localparam logic [SIZE_W-1:0] SIZE_INT8  = 2'd0;
  localparam logic [SIZE_W-1:0] SIZE_INT16 = 2'd1;
  localparam logic [SIZE_W-1:0] SIZE_INT32 = 2'd2;
  localparam logic [SIZE_W-1:0] SIZE_INT64 = 2'd3;

  localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LA   = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LZ   = 8'h7a;
  localparam logic [CHAR_W-1:0] CH_UA   = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UZ   = 8'h5a;
  localparam logic [CHAR_W-1:0] CH_TICK = 8'h60;
  localparam logic [CHAR_W-1:0] CH_LS   = 8'h73;
  localparam logic [CHAR_W-1:0] CH_LU   = 8'h75;
  localparam logic [CHAR_W-1:0] CH_LI   = 8'h69;
  localparam logic [CHAR_W-1:0] CH_LN   = 8'h6e;
  localparam logic [CHAR_W-1:0] CH_LT   = 8'h74;

  localparam logic [4*CHAR_W-1:0] STR_INT8  = "int8";
  localparam logic [5*CHAR_W-1:0] STR_INT16 = "int16";
  localparam logic [5*CHAR_W-1:0] STR_INT32 = "int32";
  localparam logic [5*CHAR_W-1:0] STR_INT64 = "int64";

  localparam logic [COUNT_W-1:0] COUNT_MAX = 3'd7;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              is_last;
  } in_item_t;

  typedef struct packed {
    logic [OUT_VALUE_W-1:0] literal_value;
    logic [RADIX_W-1:0]     radix;
    logic                   is_signed;
    logic [SIZE_W-1:0]      size_code;
  } out_item_t;

  function automatic logic [RADIX_W-1:0] prefix_base(input logic [CHAR_W-1:0] c);
    logic [RADIX_W-1:0] b;
    unique case (c)
      8'h62, 8'h42:               b = RADIX_2;
      8'h74, 8'h54:               b = RADIX_3;
      8'h6f, 8'h4f, 8'h63, 8'h43: b = RADIX_8;
      8'h64, 8'h44:               b = RADIX_10;
      8'h68, 8'h48, 8'h78, 8'h58: b = RADIX_16;
      default:                    b = RADIX_NONE;
    endcase
    return b;
  endfunction

  function automatic logic is_stop(input logic [CHAR_W-1:0] c);
    return (c == CH_LS) || (c == CH_LU) || (c == CH_LI) || (c == CH_LN) || (c == CH_LT);
  endfunction

  function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] d;
    d = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = c - CH_ZERO;
    end else if (c >= CH_LA && c <= CH_LZ) begin
      d = c - CH_LA + 8'd10;
    end else if (c >= CH_UA && c <= CH_UZ) begin
      d = c - CH_UA + 8'd10;
    end
    return d[DIGIT_W-1:0];
  endfunction

endpackage

/* hdl/integer_literal_parser.sv */
// ----------------------------------------------------------------------------
// integer_literal_parser: streaming integer literal parser
// The input channel carries one character per transaction, with is_last
// set on the final character of a literal. The result channel carries one
// transaction per literal: the value, the radix, the signed flag and the
// size code taken from an int8, int16, int32 or int64 ending, else int32.
// A character is registered when accepted and folded into the literal
// state by one shift-and-add step as it leaves, so one character is taken
// every cycle unless a final character stalls. A final character loads the
// result register as it leaves. The result register lets new characters
// keep arriving while a result waits; only a final character stalls, in
// the input register, while the previous result has not been taken.
// Reset empties both registers and returns the literal state to base 10
// with a zero value. After each result the state clears in the same way.
// ----------------------------------------------------------------------------
module integer_literal_parser
  import ilp_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic      item_vld;
  in_item_t  item;
  logic      advance;
  logic      out_free;
  out_item_t result;

  assign advance = item_vld && (!item.is_last || out_free);

  ilp_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .advance  (advance),
    .item_vld (item_vld),
    .item     (item)
  );

  ilp_core #(
    .VALUE_BITS (VALUE_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (item),
    .result (result)
  );

  ilp_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && item.is_last),
    .result    (result),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_radix_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.radix == RADIX_2 || out_data.radix == RADIX_3 ||
                   out_data.radix == RADIX_8 || out_data.radix == RADIX_10 ||
                   out_data.radix == RADIX_16))
    else $error("result radix is not a supported base");

  a_last_held: assert property (@(posedge clk) disable iff (!rst_n)
    item_vld && item.is_last && !out_free |=> item_vld && item.is_last)
    else $error("stalled final character was lost");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !item_vld |-> in_ready)
    else $error("empty input register refused a transaction");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    advance && item.is_last |=> out_valid)
    else $error("final character produced no result");

endmodule

/* hdl/ilp_in_stage.sv */
// ----------------------------------------------------------------------------
// ilp_in_stage: input register
// Holds one accepted character transaction until the parser core consumes it.
// ----------------------------------------------------------------------------
module ilp_in_stage
  import ilp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  logic     advance,
  output logic     item_vld,
  output in_item_t item
);

  logic     vld_r, vld_nxt;
  in_item_t item_r;

  assign in_ready = !vld_r || advance;
  assign vld_nxt  = (in_valid && in_ready) || (vld_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

/* hdl/ilp_core.sv */
// ----------------------------------------------------------------------------
// ilp_core: literal accumulation state
// Updates the prefix, accumulator, stop, unsigned and suffix state for one
// character per stepped cycle and forms the result on the final character.
// ----------------------------------------------------------------------------
module ilp_core
  import ilp_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  in_item_t  item,
  output out_item_t result
);

  logic [COUNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CHAR_W-1:0]     first_r, first_nxt;
  logic [RADIX_W-1:0]    base_r, base_nxt;
  logic [VALUE_BITS-1:0] acc_r, acc_nxt;
  logic                  stop_r, stop_nxt;
  logic                  saw_u_r, saw_u_nxt;
  logic [TAIL_W-1:0]     tail_r, tail_nxt;

  logic [CHAR_W-1:0]     c;
  logic [RADIX_W-1:0]    pb;
  logic                  prefix_hit;
  logic [VALUE_BITS-1:0] scaled;
  logic [SIZE_W-1:0]     size;

  assign c  = item.char_code;
  assign pb = prefix_base(c);
  assign prefix_hit = (cnt_r == COUNT_W'(1)) && (first_r == CH_ZERO) && (pb != RADIX_NONE);

  always_comb begin
    unique case (base_r)
      RADIX_2:  scaled = acc_r << 1;
      RADIX_3:  scaled = (acc_r << 1) + acc_r;
      RADIX_8:  scaled = acc_r << 3;
      RADIX_16: scaled = acc_r << 4;
      default:  scaled = (acc_r << 3) + (acc_r << 1);
    endcase
  end

  always_comb begin
    saw_u_nxt = saw_u_r || (c == CH_LU);
    tail_nxt  = {tail_r[TAIL_W-CHAR_W-1:0], c};
    first_nxt = (cnt_r == '0) ? c : first_r;
    cnt_nxt   = (cnt_r == COUNT_MAX) ? cnt_r : cnt_r + COUNT_W'(1);
    base_nxt  = base_r;
    acc_nxt   = acc_r;
    stop_nxt  = stop_r;
    if (prefix_hit) begin
      base_nxt = pb;
      acc_nxt  = '0;
    end else if (c != CH_TICK && !stop_r) begin
      if (is_stop(c)) begin
        stop_nxt = 1'b1;
      end else begin
        acc_nxt = scaled + VALUE_BITS'(digit_of(c));
      end
    end
  end

  always_comb begin
    priority if (cnt_nxt >= COUNT_W'(4) && tail_nxt[4*CHAR_W-1:0] == STR_INT8) begin
      size = SIZE_INT8;
    end else if (cnt_nxt >= COUNT_W'(5) && tail_nxt == STR_INT16) begin
      size = SIZE_INT16;
    end else if (cnt_nxt >= COUNT_W'(5) && tail_nxt == STR_INT32) begin
      size = SIZE_INT32;
    end else if (cnt_nxt >= COUNT_W'(5) && tail_nxt == STR_INT64) begin
      size = SIZE_INT64;
    end else begin
      size = SIZE_INT32;
    end
  end

  always_comb begin
    result.literal_value = OUT_VALUE_W'(acc_nxt);
    result.radix         = base_nxt;
    result.is_signed     = !saw_u_nxt;
    result.size_code     = size;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && item.is_last)) begin
      cnt_r   <= '0;
      first_r <= '0;
      base_r  <= RADIX_10;
      acc_r   <= '0;
      stop_r  <= 1'b0;
      saw_u_r <= 1'b0;
      tail_r  <= '0;
    end else if (step) begin
      cnt_r   <= cnt_nxt;
      first_r <= first_nxt;
      base_r  <= base_nxt;
      acc_r   <= acc_nxt;
      stop_r  <= stop_nxt;
      saw_u_r <= saw_u_nxt;
      tail_r  <= tail_nxt;
    end
  end

endmodule

/* hdl/ilp_out_stage.sv */
// ----------------------------------------------------------------------------
// ilp_out_stage: result register
// Holds one finished result transaction until the receiver takes it.
// ----------------------------------------------------------------------------
module ilp_out_stage
  import ilp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  out_item_t result,
  output logic      free,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic      vld_r, vld_nxt;
  out_item_t data_r;

  assign free    = !vld_r || out_ready;
  assign vld_nxt = load || (vld_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = data_r;

endmodule
